// ===== rtl/tspca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tspca_pkg
// Shared types and constants of the time-sliced pixel charge accumulator:
// field widths, request codes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tspca_pkg;

  // Field widths of the stream words
  localparam int REQ_W      = 2;
  localparam int CAM_W      = 3;
  localparam int CH_W       = 10;
  localparam int SLICE_W    = 3;
  localparam int TIME_W     = 32;
  localparam int CHG_W      = 16;
  localparam int AMP_W      = 32;
  localparam int CNT_W      = 48;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 184;

  // Configuration register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_BOUNDS = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_0  = 3'd1;

  // Request codes carried on in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_HIT       = 2'd0,
    REQ_READ_PIXEL    = 2'd1,
    REQ_READ_COUNTERS = 2'd2,
    REQ_NONE          = 2'd3
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_ROW,
    ST_ADDR,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic row;
    logic addr;
    logic read;
    logic update;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/tspca_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tspca_ctrl
// Sequencer: runs the pixel store clearing pass after reset, then steps each
// accepted word through lookup, address build, store read and update.
// ----------------------------------------------------------------------------
module tspca_ctrl
  import tspca_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_ROW;
      end
      ST_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tspca_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tspca_datapath
// Configuration registers, window match, pixel store with read-modify-write,
// photon counters and the output register.
// ----------------------------------------------------------------------------
module tspca_datapath
  import tspca_pkg::*;
#(
  parameter int MAX_SLICES   = 6,
  parameter int NUM_CAMERAS  = 8,
  parameter int NUM_CHANNELS = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  wire [IN_DATA_W-1:0]    in_tdata,
  input  wire [REQ_W-1:0]        in_tuser,
  input  wire                    cfg_valid,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  localparam int DEPTH = MAX_SLICES * NUM_CAMERAS * NUM_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [SLICE_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // Configuration
  logic [SLICE_W-1:0] slice_count_r;
  logic [TIME_W-1:0]  bound_r [NUM_BOUNDS];

  // Captured word
  req_t               req_r;
  logic [CAM_W-1:0]   cam_r;
  logic [CH_W-1:0]    ch_r;
  logic [SLICE_W-1:0] rslice_r;
  logic [TIME_W-1:0]  time_r;
  logic [CHG_W-1:0]   charge_r;

  // Lookup results
  logic               acc_r;
  logic [SLICE_W-1:0] hs_r;
  logic [SLICE_W-1:0] n_r;
  logic               access_r;
  logic               range_r;
  logic [SLICE_W-1:0] store_slice_r;
  logic [AW-1:0]      row_r;
  logic [AW-1:0]      addr_r;

  // Store
  logic [AMP_W-1:0]   mem [DEPTH];
  logic [AMP_W-1:0]   rd_data_r;
  logic [AW-1:0]      clr_addr_r;
  logic [AMP_W-1:0]   wr_data;
  logic [AMP_W:0]     sum;

  // Counters
  logic [CNT_W-1:0]   cp_r, ca_r, cd_r;
  logic [CNT_W-1:0]   cp_nxt, ca_nxt, cd_nxt;
  logic               hit_upd;

  // Output register
  logic               out_valid_r;
  logic [AMP_W-1:0]   out_amp_r;
  logic               out_acc_r;
  logic [SLICE_W-1:0] out_hs_r;
  logic [CNT_W-1:0]   out_cp_r, out_ca_r, out_cd_r;

  // Window match
  logic               in_range;
  logic               rslice_ok;
  logic               win_hit;
  logic [SLICE_W-1:0] win_slice;
  logic [SLICE_W-1:0] n_use;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_count_r <= SLICE_W'(1);
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        bound_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SLICE_COUNT) begin
        slice_count_r <= cfg_data[SLICE_W-1:0];
      end else begin
        bound_r[cfg_index - CFG_BOUNDARY_0] <= cfg_data[TIME_W-1:0];
      end
    end
  end

  // Capture accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= req_t'(in_tuser);
      cam_r    <= in_tdata[2:0];
      ch_r     <= in_tdata[12:3];
      rslice_r <= in_tdata[15:13];
      time_r   <= in_tdata[47:16];
      charge_r <= in_tdata[63:48];
    end
  end

  // Find the first window that holds the hit time
  always_comb begin
    n_use = (slice_count_r > SLICE_W'(MAX_SLICES)) ? SLICE_W'(MAX_SLICES)
                                                   : slice_count_r;
    in_range  = (32'(cam_r) < NUM_CAMERAS) && (32'(ch_r) < NUM_CHANNELS);
    rslice_ok = 32'(rslice_r) < MAX_SLICES;
    win_hit   = 1'b0;
    win_slice = '0;
    for (int s = MAX_SLICES - 1; s >= 0; s--) begin
      if (SLICE_W'(s) < n_use && time_r >= bound_r[s] && time_r < bound_r[s+1]) begin
        win_hit   = 1'b1;
        win_slice = SLICE_W'(s);
      end
    end
  end

  // Register lookup, then build the store address in two steps
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      acc_r         <= (req_r == REQ_ADD_HIT) && in_range && win_hit;
      hs_r          <= ((req_r == REQ_ADD_HIT) && in_range && win_hit) ? win_slice : '0;
      n_r           <= n_use;
      range_r       <= in_range;
      access_r      <= ((req_r == REQ_ADD_HIT) && in_range && win_hit) ||
                       ((req_r == REQ_READ_PIXEL) && in_range && rslice_ok);
      store_slice_r <= (req_r == REQ_ADD_HIT) ? win_slice : rslice_r;
    end
    if (cmd.row) begin
      row_r <= AW'(store_slice_r) * AW'(NUM_CAMERAS) + AW'(cam_r);
    end
    if (cmd.addr) begin
      addr_r <= row_r * AW'(NUM_CHANNELS) + AW'(ch_r);
    end
  end

  // Saturating charge add, or zero for a read-and-clear
  always_comb begin
    sum     = {1'b0, rd_data_r} + (AMP_W+1)'(charge_r);
    wr_data = (req_r == REQ_ADD_HIT) ? (sum[AMP_W] ? '1 : sum[AMP_W-1:0]) : '0;
  end

  // Pixel store: clearing pass, read and write-back
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.update && access_r) begin
      mem[addr_r] <= wr_data;
    end
    if (cmd.read) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // Advance the clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Counter updates
  always_comb begin
    hit_upd = (req_r == REQ_ADD_HIT) && range_r;
    cp_nxt  = hit_upd ? sat_add(cp_r, n_r) : cp_r;
    ca_nxt  = hit_upd ? sat_add(ca_r, SLICE_W'(acc_r)) : ca_r;
    cd_nxt  = hit_upd ? sat_add(cd_r, n_r - SLICE_W'(acc_r)) : cd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= '0;
      ca_r <= '0;
      cd_r <= '0;
    end else if (cmd.update) begin
      if (req_r == REQ_READ_COUNTERS) begin
        cp_r <= '0;
        ca_r <= '0;
        cd_r <= '0;
      end else begin
        cp_r <= cp_nxt;
        ca_r <= ca_nxt;
        cd_r <= cd_nxt;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_amp_r <= ((req_r == REQ_READ_PIXEL) && access_r) ? rd_data_r : '0;
      out_acc_r <= acc_r;
      out_hs_r  <= hs_r;
      out_cp_r  <= cp_nxt;
      out_ca_r  <= ca_nxt;
      out_cd_r  <= cd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_cd_r, out_ca_r, out_cp_r, out_hs_r, out_acc_r, out_amp_r};

  assign status.clear_done = (clr_addr_r == AW'(DEPTH - 1));
  assign status.out_free   = !out_valid_r || out_tready;

endmodule
`default_nettype wire

// ===== rtl/time_sliced_pixel_charge_accumulator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// time_sliced_pixel_charge_accumulator_unit
// Photoelectron hit accumulator with time windows, per-pixel charge store
// and photon counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pixel store to zero, one entry per cycle,
// over all MAX_SLICES*NUM_CAMERAS*NUM_CHANNELS entries (49152 at the
// defaults), with in_tready low; configuration writes are taken during the
// sweep. Each accepted word then passes window match, two address steps
// (slice-by-camera, then by channel), a registered store read and the
// write-back on the single store port (saturating add, or zero on a pixel
// read), which also loads the output register and waits while that register
// is full and out_tready low. The next word is accepted once the result sits
// there, one word at a time. Every request returns exactly one word.
// ----------------------------------------------------------------------------
module time_sliced_pixel_charge_accumulator_unit
  import tspca_pkg::*;
#(
  parameter int MAX_SLICES   = 6,
  parameter int NUM_CAMERAS  = 8,
  parameter int NUM_CHANNELS = 1024
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // camera[2:0], channel_index[12:3], read_slice[15:13],
  // hit_time[47:16], hit_charge[63:48]
  input  wire [IN_DATA_W-1:0]    in_tdata,
  // req_type[1:0]
  input  wire [REQ_W-1:0]        in_tuser,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // pixel_amplitude[31:0], hit_accepted[32], hit_slice[35:33],
  // count_processed[83:36], count_accepted[131:84],
  // count_discarded[179:132], zero pad[183:180]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  tspca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tspca_datapath #(
    .MAX_SLICES   (MAX_SLICES),
    .NUM_CAMERAS  (NUM_CAMERAS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
